### src/arat_pkg.sv
`default_nettype none

package arat_pkg;

    // Request modes
    localparam logic [1:0] MODE_ADD       = 2'd0;
    localparam logic [1:0] MODE_REMOVE    = 2'd1;
    localparam logic [1:0] MODE_TRANSLATE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_DUPLICATE = 2'd3;

    // One stored mapping
    typedef struct packed {
        logic [63:0] device_base;
        logic [63:0] span_length;
        logic [63:0] host_base;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;  // capture request item, clear scan results
        logic scan_rd;   // read one table entry at the scan index
        logic commit;    // apply table update and load the result register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // result register can take a new item this cycle
    } dp_status_t;

endpackage

`default_nettype wire

### src/arat_if.sv
`default_nettype none

interface arat_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] address;
    logic [63:0] span_length;
    logic [63:0] host_base;

    modport source (output valid, output mode, output address, output span_length,
                    output host_base, input ready);
    modport sink (input valid, input mode, input address, input span_length,
                  input host_base, output ready);
endinterface

interface arat_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] host_address;
    logic [1:0]  status;

    modport source (output valid, output host_address, output status, input ready);
    modport sink (input valid, input host_address, input status, output ready);
endinterface

`default_nettype wire

### src/address_range_translation_table_core.sv
`default_nettype none

// Address range translation table. Holds up to TABLE_ENTRIES mappings of
// device base, length and host base. Each request item (add, remove or
// translate) gives exactly one result item with a host address and a status
// (ok, not found, table full, duplicate base). On translate the lowest
// containing device base wins and the host address is host base plus offset.
// The table lives in a memory with one write and one registered read port
// that is walked one entry per cycle; each item is checked against every entry
// and its result committed to the output register before the next item can
// be accepted. A finished result waits in the output register while the
// next item is already accepted and scanned.
module address_range_translation_table_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    arat_req_if.sink     req,
    arat_rsp_if.source   rsp
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    arat_pkg::dp_cmd_t    cmd;
    arat_pkg::dp_status_t status;
    logic [IDX_W-1:0]     rd_idx;
    logic                 req_ready;

    arat_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd),
        .rd_idx    (rd_idx)
    );

    arat_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_idx       (rd_idx),
        .status       (status),
        .mode         (req.mode),
        .address      (req.address),
        .span_length  (req.span_length),
        .host_base    (req.host_base),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .host_address (rsp.host_address),
        .rsp_status   (rsp.status)
    );

    assign req.ready = req_ready;

endmodule

`default_nettype wire

### src/arat_ctrl.sv
`default_nettype none

module arat_ctrl #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  arat_pkg::dp_status_t     status,
    output arat_pkg::dp_cmd_t        cmd,
    output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_idx
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_LAST   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    // Sequence: take item, read every entry, check the last one, commit
    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next  = S_SCAN;
                    rd_idx_next = '0;
                end
            end
            S_SCAN:
            begin
                if (rd_idx_reg == LAST_IDX)
                    state_next = S_LAST;
                else
                    rd_idx_next = rd_idx_reg + 1'b1;
            end
            S_LAST:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // Drive handshake and datapath commands
    assign req_ready    = (state_reg == S_IDLE);
    assign cmd.load_req = (state_reg == S_IDLE) && req_valid;
    assign cmd.scan_rd  = (state_reg == S_SCAN);
    assign cmd.commit   = (state_reg == S_FINISH) && status.out_free;
    assign rd_idx       = rd_idx_reg;

endmodule

`default_nettype wire

### src/arat_datapath.sv
`default_nettype none

module arat_datapath #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  arat_pkg::dp_cmd_t        cmd,
    input  wire logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_idx,
    output arat_pkg::dp_status_t     status,
    input  wire logic [1:0]          mode,
    input  wire logic [63:0]         address,
    input  wire logic [63:0]         span_length,
    input  wire logic [63:0]         host_base,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output logic [63:0]              host_address,
    output logic [1:0]               rsp_status
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Table storage and valid bits
    arat_pkg::entry_t         mem [TABLE_ENTRIES];
    arat_pkg::entry_t         rdata_reg;
    logic [TABLE_ENTRIES-1:0] entry_valid_reg, entry_valid_next;

    // Captured request
    logic [1:0]  req_mode_reg;
    logic [63:0] req_addr_reg;
    logic [63:0] req_len_reg;
    logic [63:0] req_host_reg;

    // Check stage tag
    logic             chk_valid_reg;
    logic [IDX_W-1:0] chk_idx_reg;

    // Scan results
    logic             found_reg, found_next;
    logic [IDX_W-1:0] found_idx_reg, found_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             best_valid_reg, best_valid_next;
    logic [63:0]      best_base_reg, best_base_next;
    logic [63:0]      best_off_reg, best_off_next;
    logic [63:0]      best_host_reg, best_host_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_host_reg, out_host_next;
    logic [1:0]  out_status_reg, out_status_next;

    logic        mem_we;
    logic        ent_live;
    logic [64:0] diff;
    logic        in_range;
    logic        better;

    // Capture request item
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_mode_reg <= mode;
            req_addr_reg <= address;
            req_len_reg  <= span_length;
            req_host_reg <= host_base;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[free_idx_reg] <= '{device_base: req_addr_reg,
                                   span_length: req_len_reg,
                                   host_base:   req_host_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
            rdata_reg <= mem[rd_idx];
    end

    // Track which entry the read data belongs to
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
        end
        else
        begin
            chk_valid_reg <= cmd.scan_rd;
            chk_idx_reg   <= rd_idx;
        end
    end

    // Compare the entry in the check stage
    assign ent_live = chk_valid_reg && entry_valid_reg[chk_idx_reg];
    assign diff     = {1'b0, req_addr_reg} - {1'b0, rdata_reg.device_base};
    assign in_range = !diff[64] && (diff[63:0] < rdata_reg.span_length);
    assign better   = !best_valid_reg || (rdata_reg.device_base < best_base_reg);

    // Accumulate base match, free slot and lowest containing range
    always_comb
    begin
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_valid_next = best_valid_reg;
        best_base_next  = best_base_reg;
        best_off_next   = best_off_reg;
        best_host_next  = best_host_reg;
        if (cmd.load_req)
        begin
            found_next      = 1'b0;
            free_found_next = 1'b0;
            best_valid_next = 1'b0;
        end
        else
        begin
            if (ent_live && !found_reg && (rdata_reg.device_base == req_addr_reg))
            begin
                found_next     = 1'b1;
                found_idx_next = chk_idx_reg;
            end
            if (chk_valid_reg && !entry_valid_reg[chk_idx_reg] && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = chk_idx_reg;
            end
            if (ent_live && in_range && better)
            begin
                best_valid_next = 1'b1;
                best_base_next  = rdata_reg.device_base;
                best_off_next   = diff[63:0];
                best_host_next  = rdata_reg.host_base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            best_valid_reg <= best_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        best_base_reg <= best_base_next;
        best_off_reg  <= best_off_next;
        best_host_reg <= best_host_next;
    end

    // Commit: update the table and form the result
    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        mem_we           = 1'b0;
        out_host_next    = out_host_reg;
        out_status_next  = out_status_reg;
        if (cmd.commit)
        begin
            out_host_next   = '0;
            out_status_next = arat_pkg::ST_NOT_FOUND;
            unique case (req_mode_reg)
                arat_pkg::MODE_ADD:
                begin
                    if (found_reg)
                        out_status_next = arat_pkg::ST_DUPLICATE;
                    else if (free_found_reg)
                    begin
                        mem_we                         = 1'b1;
                        entry_valid_next[free_idx_reg] = 1'b1;
                        out_status_next                = arat_pkg::ST_OK;
                    end
                    else
                        out_status_next = arat_pkg::ST_FULL;
                end
                arat_pkg::MODE_REMOVE:
                begin
                    if (found_reg)
                    begin
                        entry_valid_next[found_idx_reg] = 1'b0;
                        out_status_next                 = arat_pkg::ST_OK;
                    end
                end
                arat_pkg::MODE_TRANSLATE:
                begin
                    if (best_valid_reg)
                    begin
                        out_host_next   = best_host_reg + best_off_reg;
                        out_status_next = arat_pkg::ST_OK;
                    end
                end
                default:
                begin
                    out_status_next = arat_pkg::ST_NOT_FOUND;
                end
            endcase
        end
    end

    // Hold the result until taken
    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_host_reg   <= out_host_next;
        out_status_reg <= out_status_next;
    end

    assign status.out_free = !out_valid_reg || rsp_ready;
    assign rsp_valid       = out_valid_reg;
    assign host_address    = out_host_reg;
    assign rsp_status      = out_status_reg;

endmodule

`default_nettype wire

### verif/arat_table_checker.sv
`default_nettype none

module arat_table_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    arat_req_if       req,
    arat_rsp_if       rsp,
    output int        fail_count,
    output int        awaited_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] host_address;
        logic [1:0]  status;
    } reply_t;

    // Shadow copy of the mapping table
    logic             map_valid [TABLE_ENTRIES];
    arat_pkg::entry_t map_entry [TABLE_ENTRIES];

    // Replies owed by the block, oldest first
    reply_t awaited_replies [$];

    // Slot holding the given device base, or -1
    function automatic int find_base(input logic [63:0] base);
        int slot;
        slot = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (map_valid[i] && map_entry[i].device_base == base)
            begin
                slot = i;
            end
        end
        return slot;
    endfunction

    // Apply one request to the shadow table and return the reply it owes
    function automatic reply_t apply_table_request(input logic [1:0] op,
                                                   input logic [63:0] addr,
                                                   input logic [63:0] span,
                                                   input logic [63:0] host);
        reply_t reply;
        int     hit;
        int     slot;
        reply.host_address = '0;
        reply.status       = arat_pkg::ST_NOT_FOUND;
        hit  = -1;
        slot = -1;
        case (op)
            arat_pkg::MODE_ADD:
            begin
                // Duplicate check comes before the fullness check
                if (find_base(addr) >= 0)
                begin
                    reply.status = arat_pkg::ST_DUPLICATE;
                end
                else
                begin
                    for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                    begin
                        if (!map_valid[i])
                        begin
                            slot = i;
                        end
                    end
                    if (slot < 0)
                    begin
                        reply.status = arat_pkg::ST_FULL;
                    end
                    else
                    begin
                        map_valid[slot]             = 1'b1;
                        map_entry[slot].device_base = addr;
                        map_entry[slot].span_length = span;
                        map_entry[slot].host_base   = host;
                        reply.status                = arat_pkg::ST_OK;
                    end
                end
            end
            arat_pkg::MODE_REMOVE:
            begin
                hit = find_base(addr);
                if (hit >= 0)
                begin
                    map_valid[hit] = 1'b0;
                    reply.status   = arat_pkg::ST_OK;
                end
            end
            arat_pkg::MODE_TRANSLATE:
            begin
                // Lowest containing base wins; range end is taken without wrap
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (map_valid[i] && map_entry[i].device_base <= addr &&
                        (addr - map_entry[i].device_base) < map_entry[i].span_length)
                    begin
                        if (hit < 0 || map_entry[i].device_base < map_entry[hit].device_base)
                        begin
                            hit = i;
                        end
                    end
                end
                if (hit >= 0)
                begin
                    reply.host_address = map_entry[hit].host_base +
                                         (addr - map_entry[hit].device_base);
                    reply.status       = arat_pkg::ST_OK;
                end
            end
            default:
            begin
                reply.status = arat_pkg::ST_NOT_FOUND;
            end
        endcase
        return reply;
    endfunction

    // Check each reply against the oldest owed one, then record new requests
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                map_valid[i] = 1'b0;
            end
            awaited_replies.delete();
            fail_count    = 0;
            awaited_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply host_address %h status %0d",
                             $time, rsp.host_address, rsp.status);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (rsp.host_address !== want.host_address)
                    begin
                        $display("%0t: host_address expected %h actual %h",
                                 $time, want.host_address, rsp.host_address);
                        fail_count = fail_count + 1;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                awaited_replies.push_back(apply_table_request(req.mode, req.address,
                                                              req.span_length,
                                                              req.host_base));
            end
            awaited_count = awaited_replies.size();
        end
    end

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         TABLE_ENTRIES = 16;
    localparam int         ITEM_TOTAL    = 1450;
    localparam int         CALM_ITEMS    = 150;
    localparam int         HOLD_CYCLES   = 400;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [63:0] base;
        logic [63:0] span;
    } span_note_t;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   awaited_count;
    int   sent_count = 0;
    bit   calm = 1'b0;
    bit   long_hold_done = 1'b0;

    // Ranges the stimulus has asked for, used to aim removes and lookups
    span_note_t  mapped_spans [$];
    logic [63:0] anchor = '0;

    arat_req_if req_ch ();
    arat_rsp_if rsp_ch ();

    address_range_translation_table_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    arat_table_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) table_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .fail_count   (fail_count),
        .awaited_count(awaited_count)
    );

    always #10 clk = ~clk;

    // Idle only outside the tail and outside every fourth block of 100 items
    function automatic bit idle_allowed();
        return !calm && ((sent_count / 100) % 4 != 3);
    endfunction

    // Offer one item at a falling edge and hold it until accepted
    task automatic send_item(input logic [1:0] op, input logic [63:0] addr,
                             input logic [63:0] span, input logic [63:0] host);
        req_ch.mode        = op;
        req_ch.address     = addr;
        req_ch.span_length = span;
        req_ch.host_base   = host;
        req_ch.valid       = 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        sent_count = sent_count + 1;
        @(negedge clk);
        if (idle_allowed() && $urandom_range(0, 99) < 30)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    // Mostly addresses clustered near the anchor, some anywhere, some at the top
    function automatic logic [63:0] pick_address();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
        begin
            return anchor + 64'($urandom_range(0, 'h7FFF));
        end
        else if (roll < 90)
        begin
            return {$urandom, $urandom};
        end
        return ALL_ONES - 64'($urandom_range(0, 'hFFF));
    endfunction

    function automatic logic [63:0] pick_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
        begin
            return '0;
        end
        else if (roll < 80)
        begin
            return 64'($urandom_range(1, 'h3000));
        end
        else if (roll < 92)
        begin
            return {$urandom, $urandom};
        end
        return ALL_ONES;
    endfunction

    // Response side: random stalls, one long hold-off to back up the input
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!long_hold_done && sent_count >= 300)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold_done = 1'b1;
            end
            else if (idle_allowed() && $urandom_range(0, 99) < 12)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                @(negedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [1:0]  op;
        logic [63:0] addr;
        logic [63:0] span;
        logic [63:0] host;
        int          roll;
        int          pick;
        int          random_items;
        span_note_t  note;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = arat_pkg::MODE_ADD;
        req_ch.address     = '0;
        req_ch.span_length = '0;
        req_ch.host_base   = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty table, unused mode
        send_item(arat_pkg::MODE_TRANSLATE, 64'h1234, '0, '0);
        send_item(MODE_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES);
        // Host sum wraps; the range end is exclusive
        send_item(arat_pkg::MODE_ADD, '0, 64'h1000, 64'hFFFF_FFFF_FFFF_F800);
        send_item(arat_pkg::MODE_TRANSLATE, 64'hFFF, '0, '0);
        send_item(arat_pkg::MODE_TRANSLATE, 64'h1000, '0, '0);
        send_item(arat_pkg::MODE_ADD, '0, 64'h20, 64'h55);
        // Range reaching past the top of the address space
        send_item(arat_pkg::MODE_ADD, 64'hFFFF_FFFF_FFFF_FF00, ALL_ONES, '0);
        send_item(arat_pkg::MODE_TRANSLATE, ALL_ONES, '0, '0);
        // Zero length holds nothing
        send_item(arat_pkg::MODE_ADD, 64'h5000, '0, 64'h7777);
        send_item(arat_pkg::MODE_TRANSLATE, 64'h5000, '0, '0);
        // Overlap: lowest base wins
        send_item(arat_pkg::MODE_ADD, 64'h800, 64'h10000, 64'hA000_0000);
        send_item(arat_pkg::MODE_TRANSLATE, 64'h900, '0, '0);
        send_item(arat_pkg::MODE_TRANSLATE, 64'h2000, '0, '0);
        // Fill the table, then overflow it and hit a duplicate while full
        for (int i = 0; i < TABLE_ENTRIES - 4; i++)
        begin
            send_item(arat_pkg::MODE_ADD, 64'h10_0000 + 64'(i) * 64'h1000, 64'h100,
                      64'(i) << 32);
        end
        send_item(arat_pkg::MODE_ADD, 64'h9999, 64'h10, 64'h1);
        send_item(arat_pkg::MODE_ADD, 64'h800, 64'h10, 64'h1);
        // Freed slot is reused; remove of an absent base
        send_item(arat_pkg::MODE_REMOVE, '0, '0, '0);
        send_item(arat_pkg::MODE_ADD, 64'h7000, 64'h40, 64'hBEEF_0000);
        send_item(arat_pkg::MODE_TRANSLATE, 64'h703F, '0, '0);
        send_item(arat_pkg::MODE_REMOVE, 64'h4444, '0, '0);

        // Random part, aimed mostly at ranges that were asked for
        random_items = ITEM_TOTAL - sent_count;
        for (int n = 0; n < random_items; n++)
        begin
            if (n % 250 == 0)
            begin
                anchor = ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom};
            end
            calm = (n >= random_items - CALM_ITEMS);
            roll = $urandom_range(0, 99);
            host = {$urandom, $urandom};
            span = pick_span();
            addr = pick_address();
            if (roll < 40)
            begin
                op = arat_pkg::MODE_ADD;
                if (mapped_spans.size() > 0 && $urandom_range(0, 99) < 15)
                begin
                    addr = mapped_spans[$urandom_range(0, mapped_spans.size() - 1)].base;
                end
                else if (mapped_spans.size() < 48)
                begin
                    mapped_spans.push_back('{addr, span});
                end
            end
            else if (roll < 65)
            begin
                op = arat_pkg::MODE_REMOVE;
                if (mapped_spans.size() > 0 && $urandom_range(0, 3) != 0)
                begin
                    pick = $urandom_range(0, mapped_spans.size() - 1);
                    addr = mapped_spans[pick].base;
                    mapped_spans.delete(pick);
                end
            end
            else if (roll < 97)
            begin
                op = arat_pkg::MODE_TRANSLATE;
                if (mapped_spans.size() > 0 && $urandom_range(0, 3) != 0)
                begin
                    note = mapped_spans[$urandom_range(0, mapped_spans.size() - 1)];
                    case ($urandom_range(0, 3))
                        0: addr = note.base;
                        1: addr = note.base + note.span - 64'd1;
                        2: addr = note.base + note.span;
                        default: addr = note.base + ((note.span == '0) ? '0 :
                                        {$urandom, $urandom} % note.span);
                    endcase
                end
            end
            else
            begin
                op = MODE_UNUSED;
            end
            send_item(op, addr, span, host);
        end
        req_ch.valid = 1'b0;

        // Drain owed replies, then let the block settle
        for (int w = 0; w < 20000 && awaited_count != 0; w++)
        begin
            @(posedge clk);
        end
        repeat (TABLE_ENTRIES + 13) @(posedge clk);
        if (fail_count == 0 && awaited_count == 0)
        begin
            $display("address_range_translation_table_core verification clean");
        end
        else
        begin
            $display("address_range_translation_table_core verification failed");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #(8_000_000);
        $display("address_range_translation_table_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
